[design/clbin_pkg.sv]
// ----------------------------------------------------------------------------
// clbin_pkg
// Shared types and constants for the particle cell list binning block.
// ----------------------------------------------------------------------------
package clbin_pkg;

    localparam int MAX_CELLS_DEF = 65536;
    localparam int MAX_PARTICLES = 65536;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int RES_W     = 17;
    localparam int PIDX_W    = 16;
    localparam int POS_W     = 32;
    localparam int LINK_W    = 17;
    localparam int CNT_W     = 17;
    localparam int CIDX_W    = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_GRID_MIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_MIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_MIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RES_X        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RES_Y        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CELLS  = 3'd6;

    localparam logic ACT_CLEAR  = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic [LINK_W-1:0] LINK_EMPTY = '1;
    localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        logic  load;
        logic  sweep_wr;
        logic  diff;
        logic  mul;
        logic  fix;
        axis_t axis;
        logic  tmul;
        logic  tadd;
        logic  lmul;
        logic  ladd;
        logic  rd;
        logic  wr_ins;
        logic  emit_zero;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic hit;
    } status_t;

endpackage

[design/particle_cell_list_binning.sv]
// ----------------------------------------------------------------------------
// particle_cell_list_binning
// Uniform-grid cell list build: per-cell head link and population table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An insert runs
// these steps before the next item can be accepted: each axis goes
// through subtract, 32x32 multiply and sign fix on one shared multiplier,
// then two multiply-add steps build the linear index, then a range check and
// one read-modify-write of the cell table memory, which is skipped when the
// particle falls outside the grid. A clear item sweeps the table one entry a
// cycle through all MAX_CELLS entries, and the same sweep runs after reset
// with busy high and no result. Every item gives one result beat: done is
// high for exactly one cycle with in_grid, cell_index, next_link and
// cell_count; it is not held, so the receiver must take it then. Config
// writes (cfg_write, cfg_index, cfg_data) land at once and belong in idle
// time only.
// ----------------------------------------------------------------------------
module particle_cell_list_binning #(
    parameter int MAX_CELLS = clbin_pkg::MAX_CELLS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 action,
    input  logic [clbin_pkg::PIDX_W-1:0]         particle_index,
    input  logic signed [clbin_pkg::POS_W-1:0]   pos_x,
    input  logic signed [clbin_pkg::POS_W-1:0]   pos_y,
    input  logic signed [clbin_pkg::POS_W-1:0]   pos_z,
    input  logic                                 cfg_write,
    input  logic [clbin_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clbin_pkg::CFG_W-1:0]          cfg_data,
    output logic                                 done,
    output logic                                 in_grid,
    output logic [clbin_pkg::CIDX_W-1:0]         cell_index,
    output logic signed [clbin_pkg::LINK_W-1:0]  next_link,
    output logic [clbin_pkg::CNT_W-1:0]          cell_count
);
    import clbin_pkg::*;

    logic signed [POS_W-1:0] grid_min_x_reg, grid_min_y_reg, grid_min_z_reg;
    logic [CFG_W-1:0]        inv_cell_size_reg;
    logic [RES_W-1:0]        res_x_reg, res_y_reg, total_cells_reg;

    cmd_t    cmd;
    status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_min_x_reg    <= '0;
            grid_min_y_reg    <= '0;
            grid_min_z_reg    <= '0;
            inv_cell_size_reg <= CFG_W'(65536);
            res_x_reg         <= RES_W'(1);
            res_y_reg         <= RES_W'(1);
            total_cells_reg   <= RES_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GRID_MIN_X:  grid_min_x_reg    <= $signed(cfg_data);
                REG_GRID_MIN_Y:  grid_min_y_reg    <= $signed(cfg_data);
                REG_GRID_MIN_Z:  grid_min_z_reg    <= $signed(cfg_data);
                REG_INV_CELL:    inv_cell_size_reg <= cfg_data;
                REG_RES_X:       res_x_reg         <= cfg_data[RES_W-1:0];
                REG_RES_Y:       res_y_reg         <= cfg_data[RES_W-1:0];
                REG_TOTAL_CELLS: total_cells_reg   <= cfg_data[RES_W-1:0];
                default: ;
            endcase
        end
    end

    clbin_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    clbin_dp #(
        .MAX_CELLS (MAX_CELLS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .particle_index (particle_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .grid_min_x     (grid_min_x_reg),
        .grid_min_y     (grid_min_y_reg),
        .grid_min_z     (grid_min_z_reg),
        .inv_cell_size  (inv_cell_size_reg),
        .res_x          (res_x_reg),
        .res_y          (res_y_reg),
        .total_cells    (total_cells_reg),
        .done           (done),
        .in_grid        (in_grid),
        .cell_index     (cell_index),
        .next_link      (next_link),
        .cell_count     (cell_count)
    );

endmodule

[design/clbin_ctrl.sv]
// ----------------------------------------------------------------------------
// clbin_ctrl
// Sequencer: clear sweep, per-axis cell coordinate steps, index build,
// table read-modify-write.
// ----------------------------------------------------------------------------
module clbin_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              action,
    input  clbin_pkg::status_t status,
    output logic              busy,
    output clbin_pkg::cmd_t   cmd
);
    import clbin_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_FIX,
        S_TMUL,
        S_TADD,
        S_LMUL,
        S_LADD,
        S_CHECK,
        S_WRITE
    } state_t;

    state_t state_reg;
    state_t state_next;
    axis_t  axis_reg;
    logic   clr_pend_reg;
    logic   busy_reg;

    assign busy = busy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP: if (status.sweep_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (action == ACT_CLEAR) ? S_SWEEP : S_DIFF;
                end
            end
            S_DIFF:  state_next = S_MUL;
            S_MUL:   state_next = S_FIX;
            S_FIX:   state_next = (axis_reg == AXIS_Z) ? S_TMUL : S_DIFF;
            S_TMUL:  state_next = S_TADD;
            S_TADD:  state_next = S_LMUL;
            S_LMUL:  state_next = S_LADD;
            S_LADD:  state_next = S_CHECK;
            S_CHECK: state_next = status.hit ? S_WRITE : S_IDLE;
            S_WRITE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.axis      = axis_reg;
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.sweep_wr  = (state_reg == S_SWEEP);
        cmd.diff      = (state_reg == S_DIFF);
        cmd.mul       = (state_reg == S_MUL);
        cmd.fix       = (state_reg == S_FIX);
        cmd.tmul      = (state_reg == S_TMUL);
        cmd.tadd      = (state_reg == S_TADD);
        cmd.lmul      = (state_reg == S_LMUL);
        cmd.ladd      = (state_reg == S_LADD);
        cmd.rd        = (state_reg == S_CHECK) && status.hit;
        cmd.wr_ins    = (state_reg == S_WRITE);
        cmd.emit_zero = ((state_reg == S_SWEEP) && status.sweep_last && clr_pend_reg)
                      || ((state_reg == S_CHECK) && !status.hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;   // table is wiped after reset
            axis_reg     <= AXIS_X;
            clr_pend_reg <= 1'b0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            if (state_reg == S_IDLE)
            begin
                axis_reg <= AXIS_X;
                if (start)
                begin
                    clr_pend_reg <= (action == ACT_CLEAR);
                end
            end
            else if (state_reg == S_FIX)
            begin
                unique case (axis_reg)
                    AXIS_X:  axis_reg <= AXIS_Y;
                    AXIS_Y:  axis_reg <= AXIS_Z;
                    default: axis_reg <= AXIS_X;
                endcase
            end
        end
    end

endmodule

[design/clbin_dp.sv]
// ----------------------------------------------------------------------------
// clbin_dp
// Datapath: cell coordinate math, linear index, range check, cell table
// (head link and population per cell) and result registers.
// ----------------------------------------------------------------------------
module clbin_dp #(
    parameter int MAX_CELLS = clbin_pkg::MAX_CELLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  clbin_pkg::cmd_t                     cmd,
    output clbin_pkg::status_t                  status,
    input  logic [clbin_pkg::PIDX_W-1:0]        particle_index,
    input  logic signed [clbin_pkg::POS_W-1:0]  pos_x,
    input  logic signed [clbin_pkg::POS_W-1:0]  pos_y,
    input  logic signed [clbin_pkg::POS_W-1:0]  pos_z,
    input  logic signed [clbin_pkg::POS_W-1:0]  grid_min_x,
    input  logic signed [clbin_pkg::POS_W-1:0]  grid_min_y,
    input  logic signed [clbin_pkg::POS_W-1:0]  grid_min_z,
    input  logic [clbin_pkg::CFG_W-1:0]         inv_cell_size,
    input  logic [clbin_pkg::RES_W-1:0]         res_x,
    input  logic [clbin_pkg::RES_W-1:0]         res_y,
    input  logic [clbin_pkg::RES_W-1:0]         total_cells,
    output logic                                done,
    output logic                                in_grid,
    output logic [clbin_pkg::CIDX_W-1:0]        cell_index,
    output logic signed [clbin_pkg::LINK_W-1:0] next_link,
    output logic [clbin_pkg::CNT_W-1:0]         cell_count
);
    import clbin_pkg::*;

    localparam int CIW    = $clog2(MAX_CELLS);
    localparam int ENT_W  = LINK_W + CNT_W;
    localparam int G_W    = POS_W + 1;          // cell coordinate
    localparam int TP_W   = G_W + RES_W + 1;    // gz * res_y
    localparam int TS_W   = TP_W + 1;           // + gy
    localparam int T_W    = 42;                 // clamped to +-2^40
    localparam int LP_W   = T_W + RES_W + 1;    // t * res_x
    localparam int LIN_W  = LP_W + 1;           // + gx

    localparam logic signed [TS_W-1:0] T_HI = TS_W'(64'sd1 <<< 40);
    localparam logic signed [TS_W-1:0] T_LO = -T_HI;

    // captured item
    logic [PIDX_W-1:0]       pidx_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, pz_reg;

    logic [POS_W-1:0]        mag_reg;
    logic                    neg_reg;
    logic [2*POS_W-1:0]      prod_reg;
    logic signed [G_W-1:0]   gx_reg, gy_reg, gz_reg;
    logic signed [TP_W-1:0]  tprod_reg;
    logic signed [T_W-1:0]   t_reg;
    logic signed [LP_W-1:0]  lprod_reg;
    logic signed [LIN_W-1:0] lin_reg;

    logic [CIW-1:0]          sweep_cnt_reg;
    logic [ENT_W-1:0]        mem [MAX_CELLS];
    logic [ENT_W-1:0]        rd_reg;

    logic signed [POS_W-1:0] pos_sel, min_sel;
    logic signed [G_W-1:0]   d;
    logic [G_W-1:0]          d_abs;
    logic [G_W-1:0]          q_ext;
    logic signed [G_W-1:0]   g_val;
    logic signed [TS_W-1:0]  tsum;
    logic                    pidx_ok;
    logic                    lin_ok;
    logic [CIW-1:0]          addr;
    logic [LINK_W-1:0]       head_old;
    logic [CNT_W-1:0]        pop_old, pop_new;

    always_comb
    begin
        unique case (cmd.axis)
            AXIS_X:
            begin
                pos_sel = px_reg;
                min_sel = grid_min_x;
            end
            AXIS_Y:
            begin
                pos_sel = py_reg;
                min_sel = grid_min_y;
            end
            default:
            begin
                pos_sel = pz_reg;
                min_sel = grid_min_z;
            end
        endcase
    end

    assign d     = G_W'(pos_sel) - G_W'(min_sel);
    assign d_abs = d[G_W-1] ? G_W'(-d) : G_W'(d);
    assign q_ext = {1'b0, prod_reg[2*POS_W-1:POS_W]};
    assign g_val = neg_reg ? -$signed(q_ext) : $signed(q_ext);

    assign tsum = TS_W'(tprod_reg) + TS_W'(gy_reg);

    assign pidx_ok = (32'(pidx_reg) < 32'(MAX_PARTICLES));
    assign lin_ok  = !lin_reg[LIN_W-1]
                   && (lin_reg[LIN_W-2:0] < (LIN_W-1)'(total_cells))
                   && (lin_reg[LIN_W-2:0] < (LIN_W-1)'(MAX_CELLS));

    assign status.hit        = pidx_ok && lin_ok;
    assign status.sweep_last = (sweep_cnt_reg == CIW'(MAX_CELLS - 1));

    assign addr     = lin_reg[CIW-1:0];
    assign head_old = rd_reg[ENT_W-1:CNT_W];
    assign pop_old  = rd_reg[CNT_W-1:0];
    assign pop_new  = (pop_old == COUNT_MAX) ? pop_old : pop_old + CNT_W'(1);

    // index math, one step per command
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pidx_reg <= particle_index;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
        end
        if (cmd.diff)
        begin
            mag_reg <= d_abs[POS_W-1:0];   // |d| < 2^32
            neg_reg <= d[G_W-1];
        end
        if (cmd.mul)
        begin
            prod_reg <= mag_reg * inv_cell_size;
        end
        if (cmd.fix)
        begin
            unique case (cmd.axis)
                AXIS_X:  gx_reg <= g_val;
                AXIS_Y:  gy_reg <= g_val;
                default: gz_reg <= g_val;
            endcase
        end
        if (cmd.tmul)
        begin
            tprod_reg <= TP_W'(gz_reg * $signed({1'b0, res_y}));
        end
        if (cmd.tadd)
        begin
            priority if (tsum > T_HI)
            begin
                t_reg <= T_W'(T_HI);
            end
            else if (tsum < T_LO)
            begin
                t_reg <= T_W'(T_LO);
            end
            else
            begin
                t_reg <= T_W'(tsum);
            end
        end
        if (cmd.lmul)
        begin
            lprod_reg <= LP_W'(t_reg * $signed({1'b0, res_x}));
        end
        if (cmd.ladd)
        begin
            lin_reg <= LIN_W'(lprod_reg) + LIN_W'(gx_reg);
        end
    end

    // cell table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_wr)
        begin
            mem[sweep_cnt_reg] <= {LINK_EMPTY, CNT_W'(0)};
        end
        else if (cmd.wr_ins)
        begin
            mem[addr] <= {LINK_W'(pidx_reg), pop_new};
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep_wr)
        begin
            sweep_cnt_reg <= status.sweep_last ? '0 : sweep_cnt_reg + CIW'(1);
        end
    end

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.emit_zero || cmd.wr_ins;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_zero)
        begin
            in_grid    <= 1'b0;
            cell_index <= '0;
            next_link  <= '0;
            cell_count <= '0;
        end
        else if (cmd.wr_ins)
        begin
            in_grid    <= 1'b1;
            cell_index <= lin_reg[CIDX_W-1:0];
            next_link  <= $signed(head_old);
            cell_count <= pop_new;
        end
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for particle_cell_list_binning. Clear and insert beats
// are queued by a stimulus thread, driven in random bursts and gaps, and
// binned by a local cell table model at accept time. Every result beat is
// checked field by field against the oldest pending expectation. The run
// starts with hand-picked grid corners and extremes, then moves to randomized
// grid settings where most particles are aimed into cells so the per-cell
// chains grow long.
// ----------------------------------------------------------------------------
module tb;
    import clbin_pkg::*;

    localparam logic [31:0] Q_ONE   = 32'h0001_0000;
    localparam logic [31:0] Q_HALF  = 32'h0000_8000;
    localparam logic [31:0] POS_MIN = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam longint      T_CLAMP = longint'(1) << 40;

    typedef struct packed {
        logic              act;
        logic [PIDX_W-1:0] pidx;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [POS_W-1:0]  pz;
    } particle_t;

    typedef struct packed {
        logic              in_grid;
        logic [CIDX_W-1:0] cidx;
        logic [LINK_W-1:0] link;
        logic [CNT_W-1:0]  count;
    } bin_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  action = ACT_CLEAR;
    logic [PIDX_W-1:0]     particle_index = '0;
    logic [POS_W-1:0]      pos_x = '0;
    logic [POS_W-1:0]      pos_y = '0;
    logic [POS_W-1:0]      pos_z = '0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_GRID_MIN_X;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  busy;
    logic                  done;
    logic                  in_grid;
    logic [CIDX_W-1:0]     cell_index;
    logic [LINK_W-1:0]     next_link;
    logic [CNT_W-1:0]      cell_count;

    // grid setting as the block should hold it
    logic [31:0]           min_x_q = '0;
    logic [31:0]           min_y_q = '0;
    logic [31:0]           min_z_q = '0;
    logic [31:0]           inv_q = 32'h0001_0000;
    logic [RES_W-1:0]      res_x_q = 17'd1;
    logic [RES_W-1:0]      res_y_q = 17'd1;
    logic [RES_W-1:0]      total_q = 17'd1;

    logic [LINK_W-1:0]     head_tab [MAX_CELLS_DEF];
    logic [CNT_W-1:0]      pop_tab  [MAX_CELLS_DEF];

    particle_t             particle_q [$];
    bin_t                  bins_due [$];

    int                    errors = 0;
    int                    n_binned = 0;
    int                    n_outside = 0;
    int                    n_clears = 0;
    int                    n_settings = 0;
    int                    deepest = 0;
    int                    gap_left = 0;
    int                    burst_left = 1;

    particle_cell_list_binning u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .particle_index (particle_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .in_grid        (in_grid),
        .cell_index     (cell_index),
        .next_link      (next_link),
        .cell_count     (cell_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timeout, %0d beats still pending", $time, particle_q.size());
        $display("FAIL particle_cell_list_binning");
        $finish;
    end

    // ------------------------------------------------------------------------
    // cell table model
    // ------------------------------------------------------------------------
    function automatic void wipe_cells();
        for (int i = 0; i < MAX_CELLS_DEF; i++)
        begin
            head_tab[i] = LINK_EMPTY;
            pop_tab[i]  = '0;
        end
    endfunction

    // truncate-toward-zero cell coordinate on one axis
    function automatic longint axis_coord(logic [31:0] pos, logic [31:0] lo);
        longint          diff;
        longint unsigned mag;
        longint unsigned inv64;
        longint unsigned prod;
        diff  = longint'($signed(pos)) - longint'($signed(lo));
        mag   = (diff < 0) ? longint'(-diff) : longint'(diff);
        inv64 = {32'b0, inv_q};
        prod  = (mag * inv64) >> 32;
        return (diff < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic bin_t bin_particle(particle_t p);
        bin_t   r;
        longint gx;
        longint gy;
        longint gz;
        longint t;
        longint lin;
        longint lim;
        r = '0;
        if (p.act == ACT_CLEAR)
        begin
            wipe_cells();
            n_clears++;
            return r;
        end
        gx = axis_coord(p.px, min_x_q);
        gy = axis_coord(p.py, min_y_q);
        gz = axis_coord(p.pz, min_z_q);
        t = gz * longint'(res_y_q) + gy;
        if (t > T_CLAMP)
            t = T_CLAMP;
        if (t < -T_CLAMP)
            t = -T_CLAMP;
        lin = t * longint'(res_x_q) + gx;
        lim = longint'(total_q);
        if (lim > MAX_CELLS_DEF)
            lim = MAX_CELLS_DEF;
        if (lin < 0 || lin >= lim)
        begin
            n_outside++;
            return r;
        end
        r.in_grid = 1'b1;
        r.cidx    = lin[15:0];
        r.link    = head_tab[lin[15:0]];
        head_tab[lin[15:0]] = {1'b0, p.pidx};
        if (pop_tab[lin[15:0]] != COUNT_MAX)
            pop_tab[lin[15:0]] = pop_tab[lin[15:0]] + 1'b1;
        r.count = pop_tab[lin[15:0]];
        n_binned++;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driver: bursts of beats with random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        particle_t taken;
        particle_t nxt;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                taken = particle_q.pop_front();
                bins_due.insert(bins_due.size(), bin_particle(taken));
            end
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (particle_q.size() != 0)
                begin
                    nxt = particle_q[0];
                    start          <= 1'b1;
                    action         <= nxt.act;
                    particle_index <= nxt.pidx;
                    pos_x          <= nxt.px;
                    pos_y          <= nxt.py;
                    pos_z          <= nxt.pz;
                    if (burst_left <= 1)
                    begin
                        burst_left <= int'($urandom_range(1, 12));
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0
                                    : int'($urandom_range(1, 24));
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        bin_t want;
        if (rst_n && done === 1'b1)
        begin
            if (bins_due.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing pending, expected none, got %0h",
                         $time, {in_grid, cell_index, next_link, cell_count});
            end
            else
            begin
                want = bins_due.pop_front();
                check_field("in_grid", 32'(want.in_grid), 32'(in_grid));
                check_field("cell_index", 32'(want.cidx), 32'(cell_index));
                check_field("next_link", 32'(want.link), 32'(next_link));
                check_field("cell_count", 32'(want.count), 32'(cell_count));
                if (in_grid === 1'b1 && int'(cell_count) > deepest)
                    deepest = int'(cell_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_insert(logic [15:0] pidx, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z);
        particle_t p;
        p.act  = ACT_INSERT;
        p.pidx = pidx;
        p.px   = x;
        p.py   = y;
        p.pz   = z;
        particle_q.insert(particle_q.size(), p);
    endfunction

    function automatic void add_clear();
        particle_t p;
        p = '0;
        p.act = ACT_CLEAR;
        p.px  = $urandom;
        p.py  = $urandom;
        p.pz  = $urandom;
        p.pidx = 16'($urandom);
        particle_q.insert(particle_q.size(), p);
    endfunction

    // position that should land near cell coordinate c on one axis
    function automatic logic [31:0] aim_pos(logic [31:0] lo, longint c);
        longint num;
        longint d;
        longint unsigned frac;
        if (inv_q == 0)
            return $urandom;
        frac = $urandom;
        num  = (c <<< 32) + longint'(frac);
        d    = num / longint'({32'b0, inv_q});
        return lo + d[31:0];
    endfunction

    function automatic void add_aimed();
        longint lim;
        longint lin;
        longint rx;
        longint ry;
        lim = (total_q > MAX_CELLS_DEF) ? MAX_CELLS_DEF : total_q;
        if (lim == 0)
            lim = 1;
        rx  = (res_x_q == 0) ? 1 : res_x_q;
        ry  = (res_y_q == 0) ? 1 : res_y_q;
        lin = $urandom_range(0, int'(lim - 1));
        add_insert(16'($urandom_range(0, 65535)),
                   aim_pos(min_x_q, lin % rx),
                   aim_pos(min_y_q, (lin / rx) % ry),
                   aim_pos(min_z_q, lin / (rx * ry)));
    endfunction

    // holds until the queue is empty, nothing is pending and the block is idle
    task automatic wait_idle();
        @(negedge clk);
        while (particle_q.size() != 0 || bins_due.size() != 0 || start || busy !== 1'b0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GRID_MIN_X:  min_x_q = val;
            REG_GRID_MIN_Y:  min_y_q = val;
            REG_GRID_MIN_Z:  min_z_q = val;
            REG_INV_CELL:    inv_q   = val;
            REG_RES_X:       res_x_q = val[RES_W-1:0];
            REG_RES_Y:       res_y_q = val[RES_W-1:0];
            REG_TOTAL_CELLS: total_q = val[RES_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                            logic [31:0] inv, logic [16:0] rx, logic [16:0] ry,
                            logic [16:0] tot);
        write_reg(REG_GRID_MIN_X, mx);
        write_reg(REG_GRID_MIN_Y, my);
        write_reg(REG_GRID_MIN_Z, mz);
        write_reg(REG_INV_CELL, inv);
        write_reg(REG_RES_X, {15'b0, rx});
        write_reg(REG_RES_Y, {15'b0, ry});
        write_reg(REG_TOTAL_CELLS, {15'b0, tot});
        @(posedge clk);
        cfg_write <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [31:0] near_origin();
        return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endfunction

    // small dense grids, wide sparse grids, full-range grids
    task automatic new_grid(int style);
        logic [31:0] inv;
        logic [16:0] rx;
        logic [16:0] ry;
        logic [16:0] tot;
        case (style)
            0:
            begin
                rx = 17'($urandom_range(1, 6));
                ry = 17'($urandom_range(1, 6));
                tot = 17'(rx * ry * $urandom_range(1, 4));
                case ($urandom_range(0, 2))
                    0: inv = Q_ONE << $urandom_range(0, 4);
                    1: inv = Q_ONE >> $urandom_range(1, 8);
                    default: inv = $urandom_range(1, 32'h0010_0000);
                endcase
                set_grid(near_origin(), near_origin(), near_origin(), inv, rx, ry, tot);
            end
            1:
            begin
                rx  = 17'($urandom_range(1, 300));
                ry  = 17'($urandom_range(1, 200));
                tot = 17'($urandom_range(1, 65536));
                set_grid(near_origin(), near_origin(), near_origin(),
                         $urandom_range(1, 32'h0100_0000), rx, ry, tot);
            end
            default:
            begin
                rx = 17'($urandom_range(1, 131071));
                ry = 17'($urandom_range(1, 131071));
                case ($urandom_range(0, 2))
                    0: tot = 17'd65536;
                    1: tot = 17'h1FFFF;
                    default: tot = 17'($urandom_range(65536, 131071));
                endcase
                set_grid($urandom, $urandom, $urandom, $urandom, rx, ry, tot);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int roll;
        wipe_cells();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset grid: one cell of unit size at the origin
        add_insert(16'd0, Q_HALF, Q_HALF, Q_HALF);
        add_insert(16'hFFFF, -Q_HALF, -Q_HALF, -Q_HALF);
        add_insert(16'd7, Q_ONE, 32'd0, 32'd0);
        add_insert(16'd8, 32'd0, -Q_ONE, 32'd0);
        add_insert(16'd9, 32'd0, 32'd0, POS_MAX);
        add_insert(16'd10, POS_MIN, 32'd0, 32'd0);
        add_insert(16'd12345, 32'd0, 32'd0, 32'd0);
        add_clear();
        add_insert(16'd3, 32'h0000_FFFF, 32'd0, 32'd0);
        wait_idle();

        // lowest corner, finest cells, widest rows, total past the table
        set_grid(POS_MIN, POS_MIN, POS_MIN, 32'hFFFF_FFFF, 17'd65536, 17'd65536, 17'h1FFFF);
        add_insert(16'd1, POS_MIN, POS_MIN, POS_MIN);
        add_insert(16'd2, POS_MIN + 2, POS_MIN, POS_MIN);
        add_insert(16'd3, POS_MIN + 32'd65536, POS_MIN, POS_MIN);
        add_insert(16'd4, POS_MIN + 32'd65537, POS_MIN, POS_MIN);
        add_insert(16'd5, POS_MIN, POS_MIN + 2, POS_MIN);
        add_insert(16'd6, POS_MAX, POS_MAX, POS_MAX);
        add_insert(16'hFFFF, POS_MIN + 1, POS_MIN + 1, POS_MIN + 1);
        wait_idle();

        // empty grid: zero total, zero scale, zero resolution
        set_grid(POS_MAX, POS_MAX, POS_MAX, 32'd0, 17'd0, 17'd0, 17'd0);
        add_insert(16'd20, POS_MIN, POS_MIN, POS_MIN);
        add_insert(16'd21, 32'd0, 32'd0, 32'd0);
        wait_idle();

        // zero resolution collapses the index onto x
        set_grid(32'd0, 32'd0, 32'd0, Q_ONE, 17'd0, 17'd0, 17'd5);
        add_insert(16'd11, 32'h0003_8000, 32'h0009_0000, 32'hFFFC_0000);
        add_insert(16'd12, 32'h0004_4000, 32'hFFF9_0000, 32'h0064_0000);
        add_insert(16'd13, 32'h0005_0000, 32'd0, 32'd0);
        add_insert(16'd14, 32'hFFFF_4000, 32'd0, 32'd0);
        add_clear();

        // randomized grids; most particles aimed into cells
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            new_grid(ph % 3);
            for (int k = 0; k < 75; k++)
            begin
                if (k == 40)
                    wait_idle();
                if (k == 20 && (ph == 2 || ph == 5 || ph == 7))
                    add_clear();
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    add_insert(16'($urandom), $urandom, $urandom, $urandom);
                else
                    add_aimed();
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (bins_due.size() != 0)
            errors++;
        $display("covered %0d inserts (%0d binned, %0d outside the grid) and %0d clears",
                 n_binned + n_outside, n_binned, n_outside, n_clears);
        $display("over %0d grid settings; longest cell chain %0d, %0d mismatches",
                 n_settings, deepest, errors);
        if (errors == 0)
            $display("PASS particle_cell_list_binning");
        else
            $display("FAIL particle_cell_list_binning");
        $finish;
    end

endmodule
